FILE: rtl/plid_pkg.sv
// Package with sizes, codes and command struct for the positional list.
`timescale 1ns / 1ps

package plid_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int FIDX_OUT_W = 4;
    localparam int LEN_OUT_W  = 5;
    localparam int FIDX_EXT_W = (IDX_W > FIDX_OUT_W) ? IDX_W : FIDX_OUT_W;
    localparam int LEN_EXT_W  = (CNT_W > LEN_OUT_W) ? CNT_W : LEN_OUT_W;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    typedef enum logic [1:0] {
        FUNC_FIND   = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  pos_idx;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

FILE: rtl/plid_cell.sv
// One list cell: holds an entry, shifts with its neighbors and compares for find.
`timescale 1ns / 1ps

module plid_cell (
    input  logic                          aclk,
    input  plid_pkg::cell_cmd_t           cmd,
    input  logic [plid_pkg::IDX_W-1:0]    my_idx,
    input  logic [plid_pkg::DATA_W-1:0]   left_data,
    input  logic [plid_pkg::DATA_W-1:0]   right_data,
    output logic [plid_pkg::DATA_W-1:0]   data,
    output logic                          match
);

    logic [plid_pkg::DATA_W-1:0] data_reg;
    logic [plid_pkg::DATA_W-1:0] data_next;
    logic [plid_pkg::CNT_W-1:0]  idx_ext;

    assign idx_ext = plid_pkg::CNT_W'(my_idx);

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (my_idx > cmd.pos_idx) begin
                data_next = left_data;
            end else if (my_idx == cmd.pos_idx) begin
                data_next = cmd.value;
            end
        end else if (cmd.del) begin
            if (my_idx >= cmd.pos_idx) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (idx_ext < cmd.count) && (data_reg == cmd.value);

endmodule

FILE: rtl/plid_prio.sv
// Priority encoder: lowest matching cell index.
`timescale 1ns / 1ps

module plid_prio (
    input  logic [plid_pkg::DEPTH-1:0] match,
    output logic                       hit,
    output logic [plid_pkg::IDX_W-1:0] idx
);

    always_comb begin
        hit = 1'b0;
        idx = '0;
        for (int i = plid_pkg::DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit = 1'b1;
                idx = plid_pkg::IDX_W'(i);
            end
        end
    end

endmodule

FILE: rtl/positional_list_insert_delete_find.sv
// Top level of the positional list: request decode, cell row and result register.
//
// Input channel s_*: one request item per handshake, tdata holds func, value
// and position. Output channel m_*: one result item per request, tdata holds
// status, found_index and length.
// Each request is decoded, checked against the current count and applied to
// a row of DEPTH cells in the cycle it is accepted; every cell compares and
// shifts in parallel.
// The result appears in the output register in the cycle after acceptance.
// Throughput is one item per cycle: a new request is taken whenever the
// output register is empty or its item is taken in the same cycle.
// When the receiver stalls, the result holds in the output register and
// s_tready drops until it is taken.
// Reset empties the list (count zero) and clears the output valid; the
// entry contents are not cleared, only entries below count are ever read.
`timescale 1ns / 1ps

module positional_list_insert_delete_find (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [plid_pkg::S_DATA_W-1:0]   s_tdata,  // func[1:0], value[33:2], position[38:34]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [plid_pkg::M_DATA_W-1:0]   m_tdata   // status[1:0], found_index[5:2], length[10:6]
);

    logic                            m_tvalid_reg;
    logic [plid_pkg::M_DATA_W-1:0]   m_tdata_reg;
    logic [plid_pkg::CNT_W-1:0]      count_reg;
    logic [plid_pkg::CNT_W-1:0]      count_next;

    logic                            accept;
    plid_pkg::func_t                 func;
    logic [plid_pkg::DATA_W-1:0]     value;
    logic [plid_pkg::POS_W-1:0]      position;
    logic [plid_pkg::CMP_W-1:0]      pos_ext;
    logic [plid_pkg::CMP_W-1:0]      cnt_ext;
    logic [plid_pkg::CMP_W-1:0]      pos_m1;
    logic                            full;
    logic                            ins_ok;
    logic                            del_ok;
    plid_pkg::status_t               status;
    logic [plid_pkg::IDX_W-1:0]      fidx;
    logic [plid_pkg::FIDX_EXT_W-1:0] fidx_ext;
    logic [plid_pkg::LEN_EXT_W-1:0]  len_ext;
    plid_pkg::cell_cmd_t             cmd;

    logic [plid_pkg::DATA_W-1:0]     cell_data [plid_pkg::DEPTH];
    logic [plid_pkg::DEPTH-1:0]      match;
    logic                            hit;
    logic [plid_pkg::IDX_W-1:0]      hit_idx;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign func     = plid_pkg::func_t'(s_tdata[1:0]);
    assign value    = s_tdata[33:2];
    assign position = s_tdata[38:34];

    assign pos_ext = plid_pkg::CMP_W'(position);
    assign cnt_ext = plid_pkg::CMP_W'(count_reg);
    assign pos_m1  = pos_ext - plid_pkg::CMP_W'(1);
    assign full    = (cnt_ext >= plid_pkg::CMP_W'(plid_pkg::DEPTH));
    assign ins_ok  = !full && (pos_ext != '0)
                     && (pos_ext <= cnt_ext + plid_pkg::CMP_W'(1));
    assign del_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

    always_comb begin
        cmd.ins     = accept && (func == plid_pkg::FUNC_INSERT) && ins_ok;
        cmd.del     = accept && (func == plid_pkg::FUNC_DELETE) && del_ok;
        cmd.pos_idx = pos_m1[plid_pkg::IDX_W-1:0];
        cmd.count   = count_reg;
        cmd.value   = value;
    end

    for (genvar i = 0; i < plid_pkg::DEPTH; i++) begin : g_cell
        logic [plid_pkg::DATA_W-1:0] left_d;
        logic [plid_pkg::DATA_W-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == plid_pkg::DEPTH - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        plid_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .my_idx     (plid_pkg::IDX_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (match[i])
        );
    end

    plid_prio u_prio (
        .match (match),
        .hit   (hit),
        .idx   (hit_idx)
    );

    always_comb begin
        count_next = count_reg;
        status     = plid_pkg::ST_OK;
        fidx       = '0;
        case (func)
            plid_pkg::FUNC_FIND: begin
                if (hit) begin
                    fidx = hit_idx;
                end else begin
                    status = plid_pkg::ST_NOTFOUND;
                end
            end
            plid_pkg::FUNC_INSERT: begin
                if (full) begin
                    status = plid_pkg::ST_FULL;
                end else if (!ins_ok) begin
                    status = plid_pkg::ST_BADPOS;
                end else begin
                    count_next = count_reg + plid_pkg::CNT_W'(1);
                end
            end
            plid_pkg::FUNC_DELETE: begin
                if (!del_ok) begin
                    status = plid_pkg::ST_BADPOS;
                end else begin
                    count_next = count_reg - plid_pkg::CNT_W'(1);
                end
            end
            default: begin
                status = plid_pkg::ST_OK;
            end
        endcase
    end

    assign fidx_ext = plid_pkg::FIDX_EXT_W'(fidx);
    assign len_ext  = plid_pkg::LEN_EXT_W'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            if (accept) begin
                m_tvalid_reg <= 1'b1;
                count_reg    <= count_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {5'b0,
                            len_ext[plid_pkg::LEN_OUT_W-1:0],
                            fidx_ext[plid_pkg::FIDX_OUT_W-1:0],
                            status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
